@@ hw/rtl/fnvh_pkg.sv @@
// ----------------------------------------------------------------------------
// fnvh_pkg
// Shared types, constants and helpers for the streaming FNV-1a name hash
// with its fmix64 finaliser.
// ----------------------------------------------------------------------------
package fnvh_pkg;

    // Hash constants
    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
    // FNV-64 prime is 2^40 + 0x1b3
    localparam int          FNV_SHL   = 40;
    localparam logic [8:0]  FNV_LO    = 9'h1b3;
    localparam logic [63:0] MIX_C1    = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;
    localparam int          MIX_SH    = 33;

    // Output selection
    localparam int HASH_BITS = 40;
    localparam int OUT_W     = 40;
    localparam int OUT_SHIFT = (64 - HASH_BITS) % 64;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Final running hash of one name, handed from front to back
    typedef struct packed {
        logic        vld;
        logic [63:0] hash;
    } t_hash_word;

    // One FNV-1a byte step: xor the byte, multiply by the prime modulo 2^64
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] hx;
        logic [63:0] lo;
        hx = h ^ {56'd0, b};
        lo = 64'(hx * {55'd0, FNV_LO});
        return (hx << FNV_SHL) + lo;
    endfunction

    // Xor-shift step of fmix64
    function automatic logic [63:0] xsh(input logic [63:0] v);
        return v ^ (v >> MIX_SH);
    endfunction

endpackage

@@ hw/rtl/fnvh_front.sv @@
// ----------------------------------------------------------------------------
// fnvh_front
// Accepts name bytes, keeps the running FNV-1a hash and hands the hash of
// each finished name to the queue.
// ----------------------------------------------------------------------------
module fnvh_front
    import fnvh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_byte_present,
    input  logic       i_last,
    output t_hash_word o_push
);

    logic [63:0] r_hash;
    logic [63:0] n_hash;
    logic [63:0] w_upd;

    // Hash the byte if one is carried
    assign w_upd = i_byte_present ? fnv_step(r_hash, i_data_byte) : r_hash;

    // Reload the basis after a last word, otherwise keep the updated hash
    always_comb begin
        n_hash = r_hash;
        if (i_accept) begin
            n_hash = i_last ? FNV_BASIS : w_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= FNV_BASIS;
        end else begin
            r_hash <= n_hash;
        end
    end

    // Hand the finished hash on
    assign o_push.vld  = i_accept & i_last;
    assign o_push.hash = w_upd;

endmodule

@@ hw/rtl/fnvh_queue.sv @@
// ----------------------------------------------------------------------------
// fnvh_queue
// Short register queue of finished running hashes between front and back.
// ----------------------------------------------------------------------------
module fnvh_queue
    import fnvh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_hash_word  i_push,
    output logic        o_full,
    input  logic        i_rd,
    output logic        o_empty,
    output logic [63:0] o_rd_data
);

    logic [63:0]     r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr;
    logic [Q_AW-1:0] r_rptr;
    logic [Q_AW:0]   r_cnt;
    logic            w_wr;
    logic            w_rd;

    assign o_full    = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign o_rd_data = r_mem[r_rptr];
    assign w_wr      = i_push.vld & ~o_full;
    assign w_rd      = i_rd & ~o_empty;

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_push.hash;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/fnvh_back.sv @@
// ----------------------------------------------------------------------------
// fnvh_back
// Runs fmix64 on each queued hash with one shared 32x32 multiplier and holds
// the result word until it is popped.
// ----------------------------------------------------------------------------
module fnvh_back
    import fnvh_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  logic [63:0]      i_q_data,
    output logic             o_q_rd,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [OUT_W-1:0] o_hash_value
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam logic [1:0] PH_LL  = 2'd0;
    localparam logic [1:0] PH_LH  = 2'd1;
    localparam logic [1:0] PH_HL  = 2'd2;
    localparam logic [1:0] PH_SUM = 2'd3;

    logic [1:0]       r_state;
    logic [1:0]       r_phase;
    logic             r_round;
    logic [63:0]      r_k;
    logic [63:0]      r_prod;
    logic [63:0]      r_acc;
    logic [31:0]      r_cross;
    logic             r_out_vld;
    logic [OUT_W-1:0] r_out;

    logic [63:0]      w_c;
    logic [31:0]      w_ma;
    logic [31:0]      w_mb;
    logic [63:0]      n_prod;
    logic [63:0]      w_mul;
    logic [63:0]      w_shifted;
    logic             w_slot_free;

    // Pick constant and operand halves for the shared multiplier
    assign w_c = r_round ? MIX_C2 : MIX_C1;

    always_comb begin
        case (r_phase)
            PH_LL: begin
                w_ma = r_k[31:0];
                w_mb = w_c[31:0];
            end
            PH_LH: begin
                w_ma = r_k[31:0];
                w_mb = w_c[63:32];
            end
            PH_HL: begin
                w_ma = r_k[63:32];
                w_mb = w_c[31:0];
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign n_prod = 64'(w_ma) * 64'(w_mb);

    // Low 64 bits of the full product from the three partial products
    assign w_mul = r_acc + {r_cross + r_prod[31:0], 32'd0};

    assign w_shifted   = r_k >> OUT_SHIFT;
    assign w_slot_free = ~r_out_vld | i_pop;
    assign o_q_rd      = (r_state == S_IDLE) & ~i_q_empty;

    // Register the partial product every cycle
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    // Sequence the two multiply rounds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_LL;
            r_round <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_state <= S_MUL;
                        r_phase <= PH_LL;
                        r_round <= 1'b0;
                    end
                end
                S_MUL: begin
                    r_phase <= r_phase + 1'b1;
                    if (r_phase == PH_SUM) begin
                        r_round <= 1'b1;
                        if (r_round) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (w_slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath: load, collect partial products, combine and xor-shift
    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_k <= xsh(i_q_data);
        end
        if (r_state == S_MUL) begin
            case (r_phase)
                PH_LH: begin
                    r_acc <= r_prod;
                end
                PH_HL: begin
                    r_cross <= r_prod[31:0];
                end
                PH_SUM: begin
                    r_k <= xsh(w_mul);
                end
                default: begin
                end
            endcase
        end
    end

    // Hold the result word until popped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if ((r_state == S_DONE) && w_slot_free) begin
            r_out_vld <= 1'b1;
        end else if (i_pop) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_slot_free) begin
            r_out <= w_shifted[OUT_W-1:0];
        end
    end

    assign o_empty      = ~r_out_vld;
    assign o_hash_value = r_out;

endmodule

@@ hw/rtl/fnv1a64_fmix_hash40_core.sv @@
// ----------------------------------------------------------------------------
// fnv1a64_fmix_hash40_core
// Streaming name hash: FNV-1a 64 over the bytes, fmix64 on the last word.
// ----------------------------------------------------------------------------
// Input channel: a word (data_byte, byte_present, last) is taken at a rising
// edge with push high and full low. Bytes with byte_present low are not
// hashed; a word with last high closes the name (an empty name if no byte
// was seen) and yields one result. Other words yield nothing.
// Result channel: while empty is low the oldest hash is on o_hash_value; it
// is taken at a rising edge with pop high.
// Throughput: one input word per cycle into the front while full is low.
// Each name then passes through fmix64 in the back (load, two rounds of
// three partial products from a shared 32x32 multiplier plus a combine step,
// then write-out); the back takes no new hash until it has written one out.
// A four-entry queue of finished hashes sits between front and back; full
// rises when it fills and only then is input refused.
// A stalled receiver keeps its word; the back then waits and the queue fills.
// Reset (synchronous, active low) empties all queues and reloads the basis.
// ----------------------------------------------------------------------------
module fnv1a64_fmix_hash40_core
    import fnvh_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  logic [7:0]       i_data_byte,
    input  logic             i_byte_present,
    input  logic             i_last,
    output logic             empty,
    input  logic             pop,
    output logic [OUT_W-1:0] o_hash_value
);

    t_hash_word  w_push;
    logic        w_q_empty;
    logic        w_q_rd;
    logic [63:0] w_q_data;
    logic        w_accept;

    assign w_accept = push & ~full;

    // Accept bytes and keep the running hash
    fnvh_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_last         (i_last),
        .o_push         (w_push)
    );

    // Queue finished hashes
    fnvh_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .o_full    (full),
        .i_rd      (w_q_rd),
        .o_empty   (w_q_empty),
        .o_rd_data (w_q_data)
    );

    // Finalise and deliver
    fnvh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (w_q_empty),
        .i_q_data     (w_q_data),
        .o_q_rd       (w_q_rd),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_hash_value (o_hash_value)
    );

endmodule

@@ bench/fnv1a64_hash_check.sv @@
// ----------------------------------------------------------------------------
// fnv1a64_hash_check
// Watches both channels of the name hash core, predicts every hash from the
// input words with its own FNV-1a 64 and fmix64 arithmetic, and compares each
// popped word with the oldest hash still expected.
// ----------------------------------------------------------------------------
module fnv1a64_hash_check
    import fnvh_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic             i_full,
    input  logic [7:0]       i_data_byte,
    input  logic             i_byte_present,
    input  logic             i_last,
    input  logic             i_empty,
    input  logic             i_pop,
    input  logic [OUT_W-1:0] i_hash_value,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01b3;

    logic [63:0]      name_hash = FNV_BASIS;
    logic [OUT_W-1:0] expected_hashes[$];
    int               fail_count = 0;

    always @(posedge i_clk) begin : track
        logic [63:0]      mix;
        logic [OUT_W-1:0] want;
        if (!i_rst_n) begin
            name_hash = FNV_BASIS;
            expected_hashes.delete();
        end else begin
            // Fold an accepted byte into the running hash; close the name on last
            if (i_push && !i_full) begin
                if (i_byte_present) begin
                    name_hash = (name_hash ^ {56'd0, i_data_byte}) * FNV_PRIME;
                end
                if (i_last) begin
                    mix = name_hash ^ (name_hash >> MIX_SH);
                    mix = mix * MIX_C1;
                    mix = mix ^ (mix >> MIX_SH);
                    mix = mix * MIX_C2;
                    mix = mix ^ (mix >> MIX_SH);
                    mix = mix >> OUT_SHIFT;
                    expected_hashes.push_back(mix[OUT_W-1:0]);
                    name_hash = FNV_BASIS;
                end
            end
            // Compare a popped word with the oldest expected hash
            if (i_pop && !i_empty) begin
                if (expected_hashes.size() == 0) begin
                    $error("hash_value: nothing expected, got %h", i_hash_value);
                    fail_count++;
                end else begin
                    want = expected_hashes.pop_front();
                    if (i_hash_value !== want) begin
                        $error("hash_value: expected %h, got %h", want, i_hash_value);
                        fail_count++;
                    end
                end
            end
        end
        o_pending    <= expected_hashes.size();
        o_fail_count <= fail_count;
    end

endmodule

@@ bench/tb_fnv1a64_fmix_hash40_core.sv @@
// ----------------------------------------------------------------------------
// tb_fnv1a64_fmix_hash40_core
// Feeds names to the hash core a byte per word, first a directed set of edge
// cases and then random names with idle words mixed in, under three patterns
// of sender and receiver stalls; the checker beside the core scores results.
// ----------------------------------------------------------------------------
module tb_fnv1a64_fmix_hash40_core;
    timeunit 1ns;
    timeprecision 1ps;

    import fnvh_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 24;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             push = 1'b0;
    logic             full;
    logic [7:0]       data_byte = 8'd0;
    logic             byte_present = 1'b0;
    logic             last = 1'b0;
    logic             empty;
    logic             pop = 1'b0;
    logic [OUT_W-1:0] hash_value;

    int hash_fails;
    int hashes_pending;
    int send_gap_pct = 11;
    int take_gap_pct = 83;
    int name_words = 0;
    int quiet_cycles = 0;

    fnv1a64_fmix_hash40_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_data_byte    (data_byte),
        .i_byte_present (byte_present),
        .i_last         (last),
        .empty          (empty),
        .pop            (pop),
        .o_hash_value   (hash_value)
    );

    fnv1a64_hash_check u_hash_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_data_byte    (data_byte),
        .i_byte_present (byte_present),
        .i_last         (last),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_hash_value   (hash_value),
        .o_fail_count   (hash_fails),
        .o_pending      (hashes_pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Abort when no word moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: stall at random according to the current phase
    initial begin
        forever begin
            @(posedge i_clk);
            pop <= ($urandom_range(99, 0) >= take_gap_pct);
        end
    end

    // Offer one word and hold it until the core takes it
    task automatic send_word(input logic [7:0] b, input logic p, input logic l);
        while ($urandom_range(99, 0) < send_gap_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push         <= 1'b1;
        data_byte    <= b;
        byte_present <= p;
        last         <= l;
        do @(posedge i_clk); while (full);
        if (p || l) begin
            name_words++;
        end
    endtask

    // Random name: bytes with the odd idle word, closed by last with or
    // without a byte
    task automatic send_name(input int len, input bit close_on_byte);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99, 0) < 8) begin
                send_word(8'($urandom), 1'b0, 1'b0);
            end
            send_word(8'($urandom), 1'b1, close_on_byte && (i == len - 1));
        end
        if (!close_on_byte || len == 0) begin
            send_word(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    // Hold the sender until every expected hash has been popped
    task automatic drain_hashes();
        push <= 1'b0;
        @(posedge i_clk);
        while (hashes_pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        int target;
        int len;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty names straight after reset and after a previous last
        send_word(8'hff, 1'b0, 1'b1);
        send_word(8'h00, 1'b0, 1'b1);
        // Single-byte names at both byte extremes
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'hff, 1'b1, 1'b1);
        // Idle words inside a name leave the hash alone; close without a byte
        send_word(8'h5a, 1'b0, 1'b0);
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'ha5, 1'b0, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h3c, 1'b0, 1'b1);
        // Walk a one through every data bit, last carrying a byte
        for (int k = 0; k < 8; k++) begin
            send_word(8'(1 << k), 1'b1, k == 7);
        end
        send_word(8'h80, 1'b1, 1'b0);
        send_word(8'h7f, 1'b1, 1'b1);

        // Random names over three stall patterns, draining between them
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_gap_pct = 11;
                    take_gap_pct = 83;
                end
                1: begin
                    send_gap_pct = 83;
                    take_gap_pct = 11;
                end
                default: begin
                    send_gap_pct = 0;
                    take_gap_pct = 0;
                end
            endcase
            target = 170 * (phase + 1);
            while (name_words < target) begin
                len = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 9)
                                                 : $urandom_range(8, 0);
                send_name(len, 1'($urandom_range(1, 0)));
            end
            drain_hashes();
        end

        // Let any stray result surface before the verdict
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (hash_fails == 0 && hashes_pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
